[hdl/lsc_pkg.sv]
// Shared types and codes for the indexed list store.
package lsc_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W = 16;
   localparam int LEN_W = 11;

   localparam logic [2:0] OP_READ     = 3'd0;
   localparam logic [2:0] OP_INS_HEAD = 3'd1;
   localparam logic [2:0] OP_INS_TAIL = 3'd2;
   localparam logic [2:0] OP_INS_AT   = 3'd3;
   localparam logic [2:0] OP_DELETE   = 3'd4;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic [2:0]              opcode;
      logic [POS_W-1:0]        position;
      logic signed [DATA_W-1:0] item_value;
   } lsc_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [1:0]              status;
      logic [LEN_W-1:0]        length_now;
   } lsc_rsp_type;

   typedef struct packed {
      logic                    ins;
      logic                    del;
      logic [POS_W-1:0]        position;
      logic [DATA_W-1:0]       item_value;
   } lsc_shift_ctl_type;

endpackage

[hdl/lsc_cell.sv]
// One storage cell of the list chain, shifting with its neighbors on insert and delete.
module lsc_cell
   import lsc_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic              clock,
   input  lsc_shift_ctl_type ctl,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0] cell_data
);

   localparam logic [POS_W-1:0] IDX = POS_W'(CELL_INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.ins && (IDX > ctl.position)) begin
         data_in = left_data;
      end else if (ctl.ins && (IDX == ctl.position)) begin
         data_in = ctl.item_value;
      end else if (ctl.del && (IDX >= ctl.position)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule

[hdl/lsc_read_tree.sv]
// Registered eight-way OR tree that selects the cell at a read position.
module lsc_read_tree
   import lsc_pkg::*;
#(
   parameter int LEAVES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [POS_W-1:0]  position,
   input  logic [DATA_W-1:0] leaf_data [LEAVES],
   output logic              out_valid,
   output logic [DATA_W-1:0] out_data
);

   localparam int FAN_SH = 3;
   localparam int FANIN = 1 << FAN_SH;

   function automatic int level_count(input int k);
      return (LEAVES + (1 << (FAN_SH * k)) - 1) >> (FAN_SH * k);
   endfunction

   function automatic int num_levels();
      int k;
      k = 1;
      while (level_count(k) > 1) begin
         k = k + 1;
      end
      return k;
   endfunction

   function automatic int level_offset(input int k);
      int off;
      off = 0;
      for (int m = 1; m < k; m++) begin
         off = off + level_count(m);
      end
      return off;
   endfunction

   localparam int LVLS = num_levels();
   localparam int TOTAL = level_offset(LVLS + 1);

   logic [DATA_W-1:0] node_ff [TOTAL];
   logic [DATA_W-1:0] node_in [TOTAL];
   logic [LVLS-1:0]   vld_ff;
   logic [LVLS-1:0]   vld_in;

   always_comb begin
      for (int k = 1; k <= LVLS; k++) begin
         for (int j = 0; j < level_count(k); j++) begin
            node_in[level_offset(k) + j] = '0;
            for (int c = 0; c < FANIN; c++) begin
               if (k == 1) begin
                  if ((j * FANIN + c) < LEAVES) begin
                     if (position == POS_W'(j * FANIN + c)) begin
                        node_in[level_offset(k) + j] = node_in[level_offset(k) + j]
                                                     | leaf_data[j * FANIN + c];
                     end
                  end
               end else begin
                  if ((j * FANIN + c) < level_count(k - 1)) begin
                     node_in[level_offset(k) + j] = node_in[level_offset(k) + j]
                                                  | node_ff[level_offset(k - 1) + j * FANIN + c];
                  end
               end
            end
         end
      end
   end

   always_comb begin
      vld_in[0] = in_valid;
      for (int k = 1; k < LVLS; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign out_valid = vld_ff[LVLS-1];
   assign out_data = node_ff[TOTAL-1];

endmodule

[hdl/indexed_list_store_core.sv]
// Top level of the indexed list store: control, cell chain, read tree and result register.
//
// The block keeps an ordered list of signed 32-bit values in a row of CAPACITY cells.
// A request beat on req_* carries an opcode, a position and a value; it is taken at a
// rising edge where req_valid is high and req_stall is low. Every request gives exactly
// one response beat on rsp_*, in request order, taken when rsp_valid is high and
// rsp_stall is low.
// Inserts and deletes shift all cells at once in the cycle the request is taken, and their
// response is valid on the next cycle; with rsp_stall low they take one beat per cycle.
// A valid read goes through the registered eight-way OR tree over the cells; its
// response is loaded into the result register once the valid bit has passed every
// tree level, and no new request is taken meanwhile. Invalid reads, rejected
// inserts and deletes, and unused opcodes answer on the next cycle.
// While a response waits with rsp_stall high, req_stall stays high.
// Synchronous reset empties the list and drops any pending response; cell contents are
// not cleared, since only cells below the length are ever read.
module indexed_list_store_core
   import lsc_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lsc_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output lsc_rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = POS_W + 1;

   typedef enum logic [0:0] {
      IDLE,
      READ
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   lsc_rsp_type       rsp_ff;
   lsc_rsp_type       rsp_in;

   logic              accept;
   logic [CMP_W-1:0]  count_ext;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  ins_pos;
   logic              is_ins;
   logic              rd_go;
   lsc_shift_ctl_type ctl;

   logic [DATA_W-1:0] cell_q [CAPACITY];
   logic              tree_valid;
   logic [DATA_W-1:0] tree_data;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff == READ) || (rsp_valid_ff && rsp_stall);
   assign count_ext = CMP_W'(count_ff);
   assign pos_ext = CMP_W'(req_payload.position);

   always_comb begin
      is_ins = 1'b0;
      ins_pos = pos_ext;
      case (req_payload.opcode)
         OP_INS_HEAD: begin
            is_ins = 1'b1;
            ins_pos = '0;
         end
         OP_INS_TAIL: begin
            is_ins = 1'b1;
            ins_pos = count_ext;
         end
         OP_INS_AT: begin
            is_ins = 1'b1;
         end
         default: begin
            is_ins = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      rd_go = 1'b0;
      ctl.ins = 1'b0;
      ctl.del = 1'b0;
      ctl.position = POS_W'(ins_pos);
      ctl.item_value = req_payload.item_value;
      rsp_in.read_value = '0;
      rsp_in.status = ST_DONE;
      case (req_payload.opcode)
         OP_READ: begin
            if (pos_ext < count_ext) begin
               rd_go = accept;
            end else begin
               rsp_in.read_value = '1;
               rsp_in.status = ST_INVALID;
            end
         end
         OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
            if (ins_pos > count_ext) begin
               rsp_in.status = ST_INVALID;
            end else if (count_ff == CNT_W'(CAPACITY)) begin
               rsp_in.status = ST_FULL;
            end else begin
               ctl.ins = accept && is_ins;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (pos_ext < count_ext) begin
               ctl.del = accept;
               count_in = count_ff - CNT_W'(1);
            end else begin
               rsp_in.status = ST_INVALID;
            end
         end
         default: begin
            rsp_in.status = ST_INVALID;
         end
      endcase
      rsp_in.length_now = LEN_W'(count_in);
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      lsc_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .left_data  ((i == 0) ? req_payload.item_value : cell_q[(i == 0) ? 0 : i - 1]),
         .right_data (cell_q[(i == CAPACITY - 1) ? i : i + 1]),
         .cell_data  (cell_q[i])
      );
   end

   lsc_read_tree #(
      .LEAVES(CAPACITY)
   ) u_read_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_go),
      .position  (req_payload.position),
      .leaf_data (cell_q),
      .out_valid (tree_valid),
      .out_data  (tree_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  count_ff <= count_in;
                  if (rd_go) begin
                     state_ff <= READ;
                     rsp_valid_ff <= 1'b0;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff <= rsp_in;
                  end
               end else if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            READ: begin
               if (tree_valid) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.read_value <= tree_data;
                  rsp_ff.status <= ST_DONE;
                  rsp_ff.length_now <= LEN_W'(count_ff);
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[dv/indexed_list_store_core_test.sv]
// Self-checking testbench for indexed_list_store_core with a shadow list predictor.
module indexed_list_store_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lsc_pkg::*;

   localparam int CAPACITY = 1024;
   localparam int RESET_CYCLES = 11;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int NOISE_PCT = 6;
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST = 3'd7;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN,
      STALL_HEAVY
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lsc_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lsc_rsp_type rsp_payload;

   stall_mode_type stall_mode = STALL_NONE;
   int stall_phase = 0;
   bit sender_gaps = 1'b0;
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;

   logic signed [DATA_W-1:0] shadow_cells [CAPACITY];
   int unsigned shadow_len = 0;
   lsc_rsp_type answers_due [$];
   int unsigned beats_taken = 0;
   int unsigned rsp_seen = 0;
   int unsigned mismatches = 0;
   int unsigned reads_seen = 0;
   int unsigned inserts_seen = 0;
   int unsigned deletes_seen = 0;
   int unsigned full_drops = 0;
   int unsigned peak_len = 0;

   indexed_list_store_core #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic flag_mismatch(input string msg);
      if (mismatches < 50) begin
         $display("mismatch at %0t ns, response %0d: %s", $time, rsp_seen, msg);
      end
      mismatches++;
   endtask

   function automatic logic [1:0] shadow_insert(int unsigned at,
                                                logic signed [DATA_W-1:0] value);
      int unsigned i;
      inserts_seen++;
      if (at > shadow_len) begin
         return ST_INVALID;
      end
      if (shadow_len >= CAPACITY) begin
         full_drops++;
         return ST_FULL;
      end
      for (i = shadow_len; i > at; i--) begin
         shadow_cells[i] = shadow_cells[i-1];
      end
      shadow_cells[at] = value;
      shadow_len++;
      if (shadow_len > peak_len) begin
         peak_len = shadow_len;
      end
      return ST_DONE;
   endfunction

   function automatic lsc_rsp_type apply_to_shadow_list(lsc_req_type beat);
      lsc_rsp_type ans;
      int unsigned i;
      ans.read_value = '0;
      ans.status = ST_DONE;
      case (beat.opcode)
         OP_READ: begin
            reads_seen++;
            if (beat.position < shadow_len) begin
               ans.read_value = shadow_cells[beat.position];
            end else begin
               ans.read_value = -1;
               ans.status = ST_INVALID;
            end
         end
         OP_INS_HEAD: ans.status = shadow_insert(0, beat.item_value);
         OP_INS_TAIL: ans.status = shadow_insert(shadow_len, beat.item_value);
         OP_INS_AT: ans.status = shadow_insert(beat.position, beat.item_value);
         OP_DELETE: begin
            deletes_seen++;
            if (beat.position < shadow_len) begin
               for (i = beat.position; i + 1 < shadow_len; i++) begin
                  shadow_cells[i] = shadow_cells[i+1];
               end
               shadow_len--;
            end else begin
               ans.status = ST_INVALID;
            end
         end
         default: ans.status = ST_INVALID;
      endcase
      ans.length_now = LEN_W'(shadow_len);
      return ans;
   endfunction

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      lsc_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (answers_due.size() == 0) begin
               flag_mismatch("response beat with no request outstanding");
            end else begin
               want = answers_due.pop_front();
               if (rsp_payload.read_value !== want.read_value) begin
                  flag_mismatch($sformatf("read_value %0d, expected %0d",
                     rsp_payload.read_value, want.read_value));
               end
               if (rsp_payload.status !== want.status) begin
                  flag_mismatch($sformatf("status %0d, expected %0d",
                     rsp_payload.status, want.status));
               end
               if (rsp_payload.length_now !== want.length_now) begin
                  flag_mismatch($sformatf("length_now %0d, expected %0d",
                     rsp_payload.length_now, want.length_now));
               end
            end
         end
         if (req_valid && !req_stall) begin
            answers_due.push_back(apply_to_shadow_list(req_payload));
            beats_taken++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= (stall_phase == 12) ? 0 : stall_phase + 1;
         case (stall_mode)
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_PATTERN: rsp_stall <= (stall_phase < 5);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
         $display("[indexed_list_store_core] ERROR");
         $finish;
      end
   end

   task automatic send_beat(input lsc_req_type beat);
      int unsigned gap;
      int unsigned ticket;
      ticket = beats_taken + 1;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_gaps ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      wait (beats_taken == ticket);
   endtask

   task automatic send_op(input logic [2:0] opcode, input logic [POS_W-1:0] position,
                          input logic signed [DATA_W-1:0] item_value);
      lsc_req_type beat;
      beat.opcode = opcode;
      beat.position = position;
      beat.item_value = item_value;
      send_beat(beat);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (answers_due.size() != 0);
   endtask

   function automatic lsc_req_type pick_beat(int unsigned ins_pct, int unsigned del_pct);
      lsc_req_type beat;
      int unsigned roll;
      beat.item_value = $urandom();
      beat.position = POS_W'($urandom_range(0, 16'hFFFF));
      roll = $urandom_range(0, 99);
      if (roll < NOISE_PCT) begin
         if ($urandom_range(0, 1) == 1) begin
            beat.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         end else begin
            beat.opcode = 3'($urandom_range(OP_READ, OP_DELETE));
         end
      end else if (roll < NOISE_PCT + ins_pct) begin
         beat.opcode = 3'($urandom_range(OP_INS_HEAD, OP_INS_AT));
         beat.position = POS_W'($urandom_range(0, shadow_len));
      end else begin
         beat.opcode = (roll < NOISE_PCT + ins_pct + del_pct) ? OP_DELETE : OP_READ;
         beat.position = (shadow_len == 0) ? '0 : POS_W'($urandom_range(0, shadow_len - 1));
         if ($urandom_range(0, 15) == 0) begin
            beat.position = POS_W'(shadow_len);
         end
      end
      return beat;
   endfunction

   task automatic test_directed();
      int k;
      stall_mode <= STALL_NONE;
      sender_gaps = 1'b0;
      send_op(OP_READ, 16'd0, 32'sd0);
      send_op(OP_DELETE, 16'd0, 32'sd0);
      send_op(OP_INS_AT, 16'd1, 32'sd5);
      send_op(OP_INS_AT, 16'd0, 32'h7FFF_FFFF);
      send_op(OP_INS_HEAD, 16'hFFFF, 32'h8000_0000);
      send_op(OP_INS_TAIL, 16'hFFFF, -32'sd1);
      send_op(OP_INS_AT, 16'd1, 32'sd0);
      send_op(OP_INS_AT, 16'hFFFF, 32'h1234_5678);
      for (k = 0; k <= 4; k++) begin
         send_op(OP_READ, POS_W'(k), 32'sd0);
      end
      send_op(OP_READ, 16'hFFFF, 32'sd0);
      for (k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++) begin
         send_op(3'(k), 16'd0, 32'hFFFF_FFFF);
      end
      send_op(OP_DELETE, 16'd3, 32'sd0);
      send_op(OP_DELETE, 16'd0, 32'sd0);
      send_op(OP_DELETE, 16'd2, 32'sd0);
      send_op(OP_DELETE, 16'hFFFF, 32'sd0);
      send_op(OP_INS_TAIL, 16'd0, 32'h5555_AAAA);
      send_op(OP_READ, 16'd2, 32'sd0);
      send_op(OP_READ, 16'd1, 32'sd0);
      drain_results();
   endtask

   task automatic test_random_short();
      int n;
      stall_mode <= STALL_RANDOM;
      sender_gaps = 1'b1;
      for (n = 0; n < 200; n++) begin
         if (n == 120) begin
            stall_mode <= STALL_NONE;
            sender_gaps = 1'b0;
         end
         if (shadow_len < 24) begin
            send_beat(pick_beat(45, 25));
         end else begin
            send_beat(pick_beat(25, 30));
         end
      end
      drain_results();
   endtask

   task automatic test_fill_to_capacity();
      stall_mode <= STALL_PATTERN;
      sender_gaps = 1'b1;
      while (shadow_len < CAPACITY) begin
         send_beat(pick_beat(90, 2));
      end
      drain_results();
   endtask

   task automatic test_full_store();
      int n;
      stall_mode <= STALL_RANDOM;
      sender_gaps = 1'b1;
      send_op(OP_INS_HEAD, 16'd0, 32'sd11);
      send_op(OP_INS_TAIL, 16'd0, 32'sd12);
      send_op(OP_INS_AT, 16'd0, 32'sd13);
      send_op(OP_INS_AT, POS_W'(CAPACITY + 1), 32'sd14);
      send_op(OP_READ, POS_W'(CAPACITY - 1), 32'sd0);
      send_op(OP_READ, POS_W'(CAPACITY), 32'sd0);
      for (n = 0; n < 60; n++) begin
         send_beat(pick_beat(45, 25));
      end
      drain_results();
   endtask

   task automatic test_shrink();
      int n;
      stall_mode <= STALL_HEAVY;
      sender_gaps = 1'b1;
      for (n = 0; n < 150; n++) begin
         send_beat(pick_beat(5, 80));
      end
      drain_results();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_short();
      test_fill_to_capacity();
      test_full_store();
      test_shrink();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (answers_due.size() != 0) begin
         flag_mismatch($sformatf("%0d responses never arrived", answers_due.size()));
      end
      $display("Sent %0d requests: %0d reads, %0d inserts (%0d refused as full), %0d deletes.",
               beats_taken, reads_seen, inserts_seen, full_drops, deletes_seen);
      $display("Checked %0d responses; the list grew to %0d of %0d entries.",
               rsp_seen, peak_len, CAPACITY);
      if (mismatches == 0) begin
         $display("[indexed_list_store_core] OK");
      end else begin
         $display("[indexed_list_store_core] ERROR");
      end
      $finish;
   end

endmodule

[indexed_list_store_core.f]
hdl/lsc_pkg.sv
hdl/lsc_cell.sv
hdl/lsc_read_tree.sv
hdl/indexed_list_store_core.sv
dv/indexed_list_store_core_test.sv
